[hdl/csg_pkg.sv]
`timescale 1ns / 1ps
// csg_pkg: shared types, constants and the boolean combine function
// for the span combine block; no dependencies
package csg_pkg;

  localparam int unsigned DIST_W = 32;
  localparam int unsigned MODE_W = 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_AND  = 2'd0,
    MODE_OR   = 2'd1,
    MODE_DIFF = 2'd2,
    MODE_XOR  = 2'd3
  } csg_mode_e;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_READ,
    ST_STEP,
    ST_FINAL
  } csg_state_e;

  function automatic logic csg_combine(csg_mode_e mode, logic l, logic r);
    logic res;
    case (mode)
      MODE_AND:  res = l & r;
      MODE_OR:   res = l | r;
      MODE_DIFF: res = l & ~r;
      default:   res = l ^ r;
    endcase
    return res;
  endfunction

endpackage

[hdl/csg_if.sv]
`timescale 1ns / 1ps
// channel interfaces of the span combine block: configuration, hit input
// and boundary output; depends on csg_pkg
interface csg_cfg_if;
  import csg_pkg::*;
  logic              valid;
  logic              ready;
  logic [MODE_W-1:0] csg_mode;

  modport source (output valid, output csg_mode, input ready);
  modport sink   (input valid, input csg_mode, output ready);
endinterface

interface csg_in_if #(parameter int unsigned TAG_BITS = 16);
  import csg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     is_end;
  logic                     hit_side;
  logic signed [DIST_W-1:0] hit_dist;
  logic [TAG_BITS-1:0]      hit_tag;

  modport source (output valid, output is_end, output hit_side, output hit_dist,
                  output hit_tag, input ready);
  modport sink   (input valid, input is_end, input hit_side, input hit_dist,
                  input hit_tag, output ready);
endinterface

interface csg_out_if #(parameter int unsigned TAG_BITS = 16);
  import csg_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [DIST_W-1:0] out_dist;
  logic [TAG_BITS-1:0]      out_tag;
  logic                     out_enters;
  logic                     out_empty;
  logic                     out_overflow;
  logic                     out_last;

  modport source (output valid, output out_dist, output out_tag, output out_enters,
                  output out_empty, output out_overflow, output out_last, input ready);
  modport sink   (input valid, input out_dist, input out_tag, input out_enters,
                  input out_empty, input out_overflow, input out_last, output ready);
endinterface

[hdl/csg_ram.sv]
`timescale 1ns / 1ps
// csg_ram: generic single write port, single read port ram with
// registered read data; no dependencies
module csg_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

[hdl/csg_span_combine.sv]
`timescale 1ns / 1ps
// a hit item is stored when it is taken, one hit per cycle while loading;
// an end item walks both lists with a ram read, then a compare and toggle
// per stored hit, and closes the run with a last read and the final state;
// the last result follows the final hit. output stalls hold the walk. no clearing pass:
// after reset the block takes items at once, counts and flags cleared
module csg_span_combine #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned TAG_BITS   = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  csg_cfg_if.sink  cfg_i,
  csg_in_if.sink   in_i,
  csg_out_if.source out_o
);
  import csg_pkg::*;

  localparam int unsigned AW = $clog2(LIST_DEPTH);
  localparam int unsigned CW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned EW = DIST_W + TAG_BITS;
  localparam logic [CW-1:0] FULL = CW'(LIST_DEPTH);

  csg_state_e state_q, state_d;
  csg_mode_e  mode_q;

  logic [CW-1:0] lcnt_q, lcnt_d, rcnt_q, rcnt_d;
  logic [CW-1:0] li_q, li_d, ri_q, ri_d;
  logic          ovf_q, ovf_d;
  logic          lin_q, lin_d, rin_q, rin_d;

  // one emitted hit held back until we know whether it is the last
  logic                     pend_vld_q, pend_vld_d;
  logic signed [DIST_W-1:0] pend_dist_q, pend_dist_d;
  logic [TAG_BITS-1:0]      pend_tag_q, pend_tag_d;
  logic                     pend_ent_q, pend_ent_d;

  logic                     out_vld_q, out_vld_d;
  logic signed [DIST_W-1:0] out_dist_q, out_dist_d;
  logic [TAG_BITS-1:0]      out_tag_q, out_tag_d;
  logic                     out_ent_q, out_ent_d;
  logic                     out_empty_q, out_empty_d;
  logic                     out_ovf_q, out_ovf_d;
  logic                     out_last_q, out_last_d;

  logic          in_acc;
  logic          we_l, we_r, rd_en;
  logic [EW-1:0] wdata, l_rdata, r_rdata;

  logic                     l_more, r_more, take_l;
  logic signed [DIST_W-1:0] l_dist, r_dist, hit_dist;
  logic [TAG_BITS-1:0]      hit_tag;
  logic                     new_lin, new_rin, before_in, after_in, emit;
  logic                     out_free, step_stall;

  assign in_acc      = in_i.valid & in_i.ready;
  assign in_i.ready  = (state_q == ST_LOAD);
  assign cfg_i.ready = 1'b1;

  // loading and the merge walk never overlap, so no forwarding is needed
  assign wdata = {in_i.hit_dist, in_i.hit_tag};
  assign we_l  = in_acc & ~in_i.is_end & ~in_i.hit_side & (lcnt_q != FULL);
  assign we_r  = in_acc & ~in_i.is_end &  in_i.hit_side & (rcnt_q != FULL);
  assign rd_en = (state_q == ST_READ);

  csg_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_left_ram (
    .clk_i   (clk_i),
    .we_i    (we_l),
    .waddr_i (lcnt_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (li_q[AW-1:0]),
    .rdata_o (l_rdata)
  );

  csg_ram #(.WIDTH(EW), .DEPTH(LIST_DEPTH)) u_right_ram (
    .clk_i   (clk_i),
    .we_i    (we_r),
    .waddr_i (rcnt_q[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (ri_q[AW-1:0]),
    .rdata_o (r_rdata)
  );

  assign l_more = (li_q < lcnt_q);
  assign r_more = (ri_q < rcnt_q);
  assign l_dist = signed'(l_rdata[EW-1:TAG_BITS]);
  assign r_dist = signed'(r_rdata[EW-1:TAG_BITS]);

  // ties go to the left list
  assign take_l   = l_more & (~r_more | (l_dist <= r_dist));
  assign hit_dist = take_l ? l_dist : r_dist;
  assign hit_tag  = take_l ? l_rdata[TAG_BITS-1:0] : r_rdata[TAG_BITS-1:0];
  assign new_lin  = lin_q ^ take_l;
  assign new_rin  = rin_q ^ ~take_l;
  assign before_in = csg_combine(mode_q, lin_q, rin_q);
  assign after_in  = csg_combine(mode_q, new_lin, new_rin);
  assign emit      = before_in ^ after_in;

  assign out_free   = ~out_vld_q | out_o.ready;
  assign step_stall = emit & pend_vld_q & ~out_free;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_acc && in_i.is_end) begin
          state_d = ST_READ;
        end
      end
      ST_READ: begin
        state_d = (l_more || r_more) ? ST_STEP : ST_FINAL;
      end
      ST_STEP: begin
        if (!step_stall) begin
          state_d = ST_READ;
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          state_d = ST_LOAD;
        end
      end
      default: state_d = ST_LOAD;
    endcase
  end

  always_comb begin
    lcnt_d      = lcnt_q;
    rcnt_d      = rcnt_q;
    ovf_d       = ovf_q;
    li_d        = li_q;
    ri_d        = ri_q;
    lin_d       = lin_q;
    rin_d       = rin_q;
    pend_vld_d  = pend_vld_q;
    pend_dist_d = pend_dist_q;
    pend_tag_d  = pend_tag_q;
    pend_ent_d  = pend_ent_q;
    out_vld_d   = out_vld_q & ~out_o.ready;
    out_dist_d  = out_dist_q;
    out_tag_d   = out_tag_q;
    out_ent_d   = out_ent_q;
    out_empty_d = out_empty_q;
    out_ovf_d   = out_ovf_q;
    out_last_d  = out_last_q;

    case (state_q)
      ST_LOAD: begin
        if (in_acc) begin
          if (in_i.is_end) begin
            li_d       = '0;
            ri_d       = '0;
            lin_d      = 1'b0;
            rin_d      = 1'b0;
            pend_vld_d = 1'b0;
          end else if (!in_i.hit_side) begin
            if (lcnt_q != FULL) lcnt_d = lcnt_q + CW'(1);
            else                ovf_d  = 1'b1;
          end else begin
            if (rcnt_q != FULL) rcnt_d = rcnt_q + CW'(1);
            else                ovf_d  = 1'b1;
          end
        end
      end
      ST_STEP: begin
        if (!step_stall) begin
          if (take_l) li_d = li_q + CW'(1);
          else        ri_d = ri_q + CW'(1);
          lin_d = new_lin;
          rin_d = new_rin;
          if (emit) begin
            if (pend_vld_q) begin
              out_vld_d   = 1'b1;
              out_dist_d  = pend_dist_q;
              out_tag_d   = pend_tag_q;
              out_ent_d   = pend_ent_q;
              out_empty_d = 1'b0;
              out_ovf_d   = ovf_q;
              out_last_d  = 1'b0;
            end
            pend_vld_d  = 1'b1;
            pend_dist_d = hit_dist;
            pend_tag_d  = hit_tag;
            pend_ent_d  = after_in;
          end
        end
      end
      ST_FINAL: begin
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_ovf_d   = ovf_q;
          out_last_d  = 1'b1;
          out_empty_d = ~pend_vld_q;
          out_dist_d  = pend_vld_q ? pend_dist_q : '0;
          out_tag_d   = pend_vld_q ? pend_tag_q : '0;
          out_ent_d   = pend_vld_q & pend_ent_q;
          pend_vld_d  = 1'b0;
          lcnt_d      = '0;
          rcnt_d      = '0;
          ovf_d       = 1'b0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_LOAD;
      mode_q     <= MODE_AND;
      lcnt_q     <= '0;
      rcnt_q     <= '0;
      ovf_q      <= 1'b0;
      li_q       <= '0;
      ri_q       <= '0;
      lin_q      <= 1'b0;
      rin_q      <= 1'b0;
      pend_vld_q <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      if (cfg_i.valid && cfg_i.ready) begin
        mode_q <= csg_mode_e'(cfg_i.csg_mode);
      end
      lcnt_q     <= lcnt_d;
      rcnt_q     <= rcnt_d;
      ovf_q      <= ovf_d;
      li_q       <= li_d;
      ri_q       <= ri_d;
      lin_q      <= lin_d;
      rin_q      <= rin_d;
      pend_vld_q <= pend_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_dist_q <= pend_dist_d;
    pend_tag_q  <= pend_tag_d;
    pend_ent_q  <= pend_ent_d;
    out_dist_q  <= out_dist_d;
    out_tag_q   <= out_tag_d;
    out_ent_q   <= out_ent_d;
    out_empty_q <= out_empty_d;
    out_ovf_q   <= out_ovf_d;
    out_last_q  <= out_last_d;
  end

  assign out_o.valid        = out_vld_q;
  assign out_o.out_dist     = out_dist_q;
  assign out_o.out_tag      = out_tag_q;
  assign out_o.out_enters   = out_ent_q;
  assign out_o.out_empty    = out_empty_q;
  assign out_o.out_overflow = out_ovf_q;
  assign out_o.out_last     = out_last_q;

endmodule

[hdl/csg_checker.sv]
`timescale 1ns / 1ps
// csg_checker: port level checks of the span combine block, attached to
// the top level by the bind below; depends on csg_pkg
module csg_checker #(
  parameter int unsigned TAG_BITS = 16
) (
  input logic                             clk_i,
  input logic                             rst_ni,
  input logic                             in_valid_i,
  input logic                             in_ready_i,
  input logic                             in_is_end_i,
  input logic                             out_valid_i,
  input logic                             out_ready_i,
  input logic signed [csg_pkg::DIST_W-1:0] out_dist_i,
  input logic [TAG_BITS-1:0]              out_tag_i,
  input logic                             out_enters_i,
  input logic                             out_empty_i,
  input logic                             out_last_i
);
  import csg_pkg::*;

  // a stalled result holds
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_dist_i)
      && $stable(out_tag_i) && $stable(out_last_i))
    else $error("stalled result changed");

  // the empty marker only closes a run and carries no hit
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_empty_i |-> out_last_i && out_dist_i == '0
      && out_tag_i == '0 && !out_enters_i)
    else $error("empty result malformed");

  // an end transfer stops loading while the lists are walked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_is_end_i |=> !in_ready_i)
    else $error("input taken during merge");

  // a result that is not the last means the merge is still running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !in_ready_i)
    else $error("loading while a run is open");

endmodule

bind csg_span_combine csg_checker #(.TAG_BITS(TAG_BITS)) u_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_is_end_i  (in_i.is_end),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_dist_i   (out_o.out_dist),
  .out_tag_i    (out_o.out_tag),
  .out_enters_i (out_o.out_enters),
  .out_empty_i  (out_o.out_empty),
  .out_last_i   (out_o.out_last)
);

[bench/csg_span_combine_tb.sv]
`timescale 1ns / 1ps
// csg_span_combine_tb: self-checking bench for the span combine block; drives hit
// lists and end items, predicts the boundary hits and checks every result transfer
// depends on csg_pkg, the channel interfaces in hdl/csg_if.sv and csg_span_combine
module csg_span_combine_tb;
  import csg_pkg::*;

  localparam int LIST_DEPTH  = 32;
  localparam int TAG_BITS    = 16;
  localparam int N_ITEMS     = 260;
  localparam int PHASE_ITEMS = 40;
  localparam int HOLD_CYC    = 300;
  localparam int SETTLE_CYC  = 4 * LIST_DEPTH + 8;
  localparam int STALL_LIMIT = 4000;
  localparam int DIST_MIN    = -2147483647 - 1;
  localparam int DIST_MAX    = 2147483647;

  typedef struct packed {
    logic                     is_end;
    logic                     hit_side;
    logic signed [DIST_W-1:0] hit_dist;
    logic [TAG_BITS-1:0]      hit_tag;
  } hit_item_t;

  typedef struct {
    logic signed [DIST_W-1:0] tpos;
    logic [TAG_BITS-1:0]      tag;
  } span_entry_t;

  typedef struct {
    logic signed [DIST_W-1:0] tpos;
    logic [TAG_BITS-1:0]      tag;
    logic                     enters;
    logic                     empty;
    logic                     overflow;
    logic                     last;
  } bound_t;

  // keeps its own copy of both hit lists and works out the boundary hits
  class span_checker;
    span_entry_t left_hits[LIST_DEPTH];
    span_entry_t right_hits[LIST_DEPTH];
    int          left_cnt;
    int          right_cnt;
    bit          dropped;
    csg_mode_e   mode;
    bound_t      due_bounds[$];
    int unsigned mismatches;
    int unsigned checked;

    function new();
      left_cnt   = 0;
      right_cnt  = 0;
      dropped    = 1'b0;
      mode       = MODE_AND;
      mismatches = 0;
      checked    = 0;
    endfunction

    function void set_mode(csg_mode_e m);
      mode = m;
    endfunction

    function int pending();
      return due_bounds.size();
    endfunction

    function bit solid_inside(bit l, bit r);
      case (mode)
        MODE_AND:  return l && r;
        MODE_OR:   return l || r;
        MODE_DIFF: return l && !r;
        default:   return l != r;
      endcase
    endfunction

    function void merge_spans();
      bound_t      run[$];
      bound_t      b;
      span_entry_t h;
      int          li;
      int          ri;
      bit          l_in;
      bit          r_in;
      bit          was;
      bit          now;
      bit          take_l;
      li   = 0;
      ri   = 0;
      l_in = 1'b0;
      r_in = 1'b0;
      while (li < left_cnt || ri < right_cnt) begin
        // equal distance: the left hit goes first
        take_l = (li < left_cnt) &&
                 ((ri >= right_cnt) || (left_hits[li].tpos <= right_hits[ri].tpos));
        was = solid_inside(l_in, r_in);
        if (take_l) begin
          h = left_hits[li];
          li++;
          l_in = !l_in;
        end else begin
          h = right_hits[ri];
          ri++;
          r_in = !r_in;
        end
        now = solid_inside(l_in, r_in);
        if (was != now && run.size() < 2 * LIST_DEPTH) begin
          b.tpos     = h.tpos;
          b.tag      = h.tag;
          b.enters   = now;
          b.empty    = 1'b0;
          b.overflow = dropped;
          b.last     = 1'b0;
          run.insert(run.size(), b);
        end
      end
      if (run.size() == 0) begin
        b.tpos     = '0;
        b.tag      = '0;
        b.enters   = 1'b0;
        b.empty    = 1'b1;
        b.overflow = dropped;
        b.last     = 1'b0;
        run.insert(run.size(), b);
      end
      foreach (run[i]) begin
        b      = run[i];
        b.last = (i == run.size() - 1);
        due_bounds.insert(due_bounds.size(), b);
      end
      left_cnt  = 0;
      right_cnt = 0;
      dropped   = 1'b0;
    endfunction

    function void take_item(hit_item_t it);
      span_entry_t e;
      e.tpos = it.hit_dist;
      e.tag  = it.hit_tag;
      if (it.is_end) begin
        merge_spans();
      end else if (!it.hit_side) begin
        if (left_cnt < LIST_DEPTH) begin
          left_hits[left_cnt] = e;
          left_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end else begin
        if (right_cnt < LIST_DEPTH) begin
          right_hits[right_cnt] = e;
          right_cnt++;
        end else begin
          dropped = 1'b1;
        end
      end
    endfunction

    function void check_bound(bound_t got);
      bound_t want;
      checked++;
      if (due_bounds.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("boundary %0d arrived with none expected: dist=%0d tag=%h last=%b",
                   checked, got.tpos, got.tag, got.last);
        return;
      end
      want = due_bounds.pop_front();
      if (got.tpos !== want.tpos || got.tag !== want.tag || got.enters !== want.enters ||
          got.empty !== want.empty || got.overflow !== want.overflow ||
          got.last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"boundary %0d mismatch: expected dist=%0d tag=%h enters=%b empty=%b ",
                    "ovf=%b last=%b, got dist=%0d tag=%h enters=%b empty=%b ovf=%b last=%b"},
                   checked, want.tpos, want.tag, want.enters, want.empty, want.overflow,
                   want.last, got.tpos, got.tag, got.enters, got.empty, got.overflow,
                   got.last);
      end
    endfunction
  endclass

  logic clk_i;
  logic rst_ni = 1'b0;

  csg_cfg_if                       cfg_if ();
  csg_in_if  #(.TAG_BITS(TAG_BITS)) hit_if ();
  csg_out_if #(.TAG_BITS(TAG_BITS)) bnd_if ();

  csg_span_combine #(
    .LIST_DEPTH(LIST_DEPTH),
    .TAG_BITS  (TAG_BITS)
  ) i_dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .cfg_i (cfg_if),
    .in_i  (hit_if),
    .out_o (bnd_if)
  );

  span_checker chk;
  int          items_sent   = 0;
  int          tx_burst     = 0;
  int          rx_burst     = 0;
  int          quiet_cycles = 0;

  always begin
    clk_i = 1'b0;
    #10;
    clk_i = 1'b1;
    #10;
  end

  // occasional runs of back-to-back transfers, otherwise a random gap before each transfer
  function automatic int next_gap(inout int burst);
    if (burst > 0) begin
      burst--;
      return 0;
    end
    if ($urandom_range(0, 7) == 0) begin
      burst = $urandom_range(4, 20);
      return 0;
    end
    return $urandom_range(0, 4);
  endfunction

  function automatic int pick_dist(int span);
    case ($urandom_range(0, 11))
      0:       return DIST_MIN;
      1:       return DIST_MAX;
      default: begin
        if (span == 0) return int'($urandom);
        return int'($urandom_range(0, 2 * span)) - span;
      end
    endcase
  endfunction

  task automatic send_item(input hit_item_t it);
    int gap;
    gap = next_gap(tx_burst);
    @(negedge clk_i);
    if (gap != 0) begin
      hit_if.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    hit_if.valid    <= 1'b1;
    hit_if.is_end   <= it.is_end;
    hit_if.hit_side <= it.hit_side;
    hit_if.hit_dist <= it.hit_dist;
    hit_if.hit_tag  <= it.hit_tag;
    @(posedge clk_i);
    while (!hit_if.ready) @(posedge clk_i);
    chk.take_item(it);
    items_sent++;
  endtask

  task automatic send_hit(input bit side, input int dist_v, input int tag);
    hit_item_t it;
    it.is_end   = 1'b0;
    it.hit_side = side;
    it.hit_dist = dist_v;
    it.hit_tag  = TAG_BITS'(tag);
    send_item(it);
  endtask

  // the other fields of an end item are don't-care, so they carry noise
  task automatic send_end();
    hit_item_t it;
    it.is_end   = 1'b1;
    it.hit_side = 1'($urandom_range(0, 1));
    it.hit_dist = $urandom;
    it.hit_tag  = TAG_BITS'($urandom_range(0, 65535));
    send_item(it);
  endtask

  task automatic run_ray(input int nl, input int nr, input bit sorted, input int span);
    int lq[$];
    int rq[$];
    int a;
    int b;
    repeat (nl) lq.insert(lq.size(), pick_dist(span));
    repeat (nr) rq.insert(rq.size(), pick_dist(span));
    if (sorted) begin
      lq.sort();
      rq.sort();
    end
    a = 0;
    b = 0;
    while (a < nl || b < nr) begin
      if (a < nl && (b >= nr || $urandom_range(0, 1) == 1)) begin
        send_hit(1'b0, lq[a], $urandom_range(0, 65535));
        a++;
      end else begin
        send_hit(1'b1, rq[b], $urandom_range(0, 65535));
        b++;
      end
    end
    send_end();
  endtask

  task automatic random_ray();
    int k;
    k = $urandom_range(0, 99);
    if (k < 60) begin
      // small span gives plenty of equal distances
      run_ray($urandom_range(0, 6), $urandom_range(0, 6), 1'b1,
              ($urandom_range(0, 1) == 1) ? 0 : 6);
    end else if (k < 80) begin
      run_ray($urandom_range(0, 6), $urandom_range(0, 6), 1'b0, 0);
    end else if (k < 95) begin
      if ($urandom_range(0, 1) == 1) run_ray($urandom_range(0, 4), 0, 1'b1, 0);
      else run_ray(0, $urandom_range(0, 4), 1'b1, 0);
    end else begin
      if ($urandom_range(0, 1) == 1) run_ray(LIST_DEPTH + 1, $urandom_range(0, 2), 1'b1, 6);
      else run_ray($urandom_range(0, 2), LIST_DEPTH + 1, 1'b0, 0);
    end
  endtask

  // drop valid, let every boundary arrive and the block wind down
  task automatic settle_idle();
    @(negedge clk_i);
    hit_if.valid <= 1'b0;
    while (chk.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYC) @(posedge clk_i);
  endtask

  task automatic write_mode(input csg_mode_e m);
    @(negedge clk_i);
    cfg_if.valid    <= 1'b1;
    cfg_if.csg_mode <= m;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    chk.set_mode(m);
    @(negedge clk_i);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin : stimulus
    int        ph;
    int        ph_start;
    csg_mode_e m;
    chk             = new();
    cfg_if.valid    = 1'b0;
    cfg_if.csg_mode = MODE_AND;
    hit_if.valid    = 1'b0;
    hit_if.is_end   = 1'b0;
    hit_if.hit_side = 1'b0;
    hit_if.hit_dist = '0;
    hit_if.hit_tag  = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    write_mode(MODE_AND);
    // merge with nothing loaded
    send_end();
    // extreme distances and tags
    send_hit(1'b0, DIST_MIN, 'h0000);
    send_hit(1'b1, DIST_MAX, 'hffff);
    send_end();
    // equal distances on both sides
    send_hit(1'b0, 'h0005_0000, 'h1111);
    send_hit(1'b1, 'h0005_0000, 'h2222);
    send_hit(1'b1, 'h0008_0000, 'h3333);
    send_hit(1'b0, 'h0008_0000, 'h4444);
    send_end();
    // unsorted left list
    send_hit(1'b0, 100, 'haaaa);
    send_hit(1'b0, -100, 'h5555);
    send_hit(1'b1, 0, 'h0f0f);
    send_end();
    // right list only
    send_hit(1'b1, -1, 'h8000);
    send_hit(1'b1, 1, 'h0001);
    send_end();

    ph = 0;
    while (items_sent < N_ITEMS) begin
      settle_idle();
      case (ph)
        0:       m = MODE_XOR;
        1:       m = MODE_OR;
        2:       m = MODE_DIFF;
        3:       m = MODE_AND;
        default: m = csg_mode_e'($urandom_range(0, 3));
      endcase
      write_mode(m);
      ph_start = items_sent;
      // both lists full: every hit toggles the xor, so the most results per run
      if (ph == 0) run_ray(LIST_DEPTH, LIST_DEPTH, 1'b1, 0);
      // one hit too many for the left list
      if (ph == 1) run_ray(LIST_DEPTH + 1, 1, 1'b1, 0);
      while (items_sent - ph_start < PHASE_ITEMS && items_sent < N_ITEMS) random_ray();
      ph++;
    end

    settle_idle();
    if (chk.mismatches == 0) $display("TEST PASSED");
    else $display("TEST FAILED");
    $finish;
  end

  initial begin : bound_sink
    bound_t b;
    int     gap;
    int     got_cnt;
    bit     held;
    bnd_if.ready = 1'b0;
    got_cnt      = 0;
    held         = 1'b0;
    @(posedge rst_ni);
    forever begin
      gap = next_gap(rx_burst);
      // one long hold-off while hits keep coming, so the block backs up
      if (!held && got_cnt == 4) begin
        gap  = HOLD_CYC;
        held = 1'b1;
      end
      @(negedge clk_i);
      if (gap != 0) begin
        bnd_if.ready <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      bnd_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!bnd_if.valid) @(posedge clk_i);
      b.tpos     = bnd_if.out_dist;
      b.tag      = bnd_if.out_tag;
      b.enters   = bnd_if.out_enters;
      b.empty    = bnd_if.out_empty;
      b.overflow = bnd_if.out_overflow;
      b.last     = bnd_if.out_last;
      chk.check_bound(b);
      got_cnt++;
    end
  end

  always @(posedge clk_i) begin
    if ((hit_if.valid && hit_if.ready) || (bnd_if.valid && bnd_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

endmodule

[files.f]
hdl/csg_pkg.sv
hdl/csg_if.sv
hdl/csg_ram.sv
hdl/csg_span_combine.sv
hdl/csg_checker.sv
bench/csg_span_combine_tb.sv
